// File: rtl/flcs_pkg.sv
// ----------------------------------------------------------------------------
// flcs_pkg
// Types, register codes and level tables for the flash LED command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package flcs_pkg;

  // Command codes
  localparam logic [1:0] OP_OFF    = 2'd0;
  localparam logic [1:0] OP_FLASH  = 2'd1;
  localparam logic [1:0] OP_STROBE = 2'd2;
  localparam logic [1:0] OP_TORCH  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASK_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_FLASH_LVL_EN = 2'd1;
  localparam logic [1:0] CFG_TORCH_LVL_EN = 2'd2;

  // Driver register addresses
  localparam logic [7:0] ADDR_FEATURES = 8'h08;
  localparam logic [7:0] ADDR_CURRENT  = 8'h09;
  localparam logic [7:0] ADDR_ENABLE   = 8'h0A;

  // Enable and features bytes
  localparam logic [7:0] EN_OFF        = 8'h00;
  localparam logic [7:0] EN_TORCH      = 8'h82;
  localparam logic [7:0] EN_FLASH_BASE = 8'h03;
  localparam logic [7:0] EN_VIN_MON    = 8'h80;
  localparam logic [7:0] EN_TX_MASK    = 8'h40;
  localparam logic [7:0] EN_STROBE     = 8'h20;
  localparam logic [7:0] FEATURES_VAL  = 8'h0D;

  localparam logic [3:0] FLASH_DEF_LVL  = 4'd7;
  localparam logic [3:0] FLASH_HIGH_LVL = 4'd7;
  localparam logic [2:0] TORCH_DEF_LVL  = 3'd2;
  localparam logic [2:0] TORCH_HIGH_LVL = 3'd7;
  localparam logic [11:0] FLASH_MAX_MA  = 12'd1500;
  localparam logic [11:0] TORCH_MAX_MA  = 12'd375;

  localparam int FlashLevels = 16;
  localparam int TorchLevels = 8;

  localparam logic [10:0] FLASH_MA [FlashLevels] = '{
    11'd94,   11'd188,  11'd281,  11'd375,  11'd469,  11'd563,  11'd656,  11'd750,
    11'd844,  11'd938,  11'd1031, 11'd1125, 11'd1219, 11'd1313, 11'd1406, 11'd1500
  };
  localparam logic [8:0] TORCH_MA [TorchLevels] = '{
    9'd47, 9'd94, 9'd141, 9'd188, 9'd234, 9'd281, 9'd328, 9'd375
  };

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] current_ma;
    logic [7:0]  flags_byte;
    logic [7:0]  current_reg_byte;
    logic        read_failed;
  } cmd_t;

  typedef struct packed {
    logic mask_enable;
    logic flash_level_configured;
    logic torch_level_configured;
  } cfg_t;

  typedef struct packed {
    logic       last;
    logic       under_voltage;
    logic       overvolt_or_short;
    logic       over_temp;
    logic       status;
    logic       write_valid;
    logic [7:0] reg_value;
    logic [7:0] reg_address;
  } res_t;

  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } job_t;

  // Nearest level, ties upward: level k is reached once 2*cur >= t[k-1]+t[k].
  function automatic logic [3:0] flash_nearest(input logic [11:0] cur);
    logic [3:0] lvl;
    lvl = '0;
    for (int k = 1; k < FlashLevels; k++) begin
      if ({1'b0, cur, 1'b0} >= (14'(FLASH_MA[k-1]) + 14'(FLASH_MA[k]))) begin
        lvl = 4'(k);
      end
    end
    return lvl;
  endfunction

  function automatic logic [2:0] torch_nearest(input logic [11:0] cur);
    logic [2:0] lvl;
    lvl = '0;
    for (int k = 1; k < TorchLevels; k++) begin
      if ({1'b0, cur, 1'b0} >= (14'(TORCH_MA[k-1]) + 14'(TORCH_MA[k]))) begin
        lvl = 3'(k);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: rtl/flash_led_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// flash_led_command_sequencer_unit
// Accepts LED driver commands and streams out the register writes (or a status-only result) for each.
// ----------------------------------------------------------------------------
// Path: a command passes in_q, job_q and out_q before its first write leaves.
// Throughput: one write per cycle from out_q while m_axis_tready is high; off
// or an aborted command gives one result, torch two, flash three; a new command
// enters while the previous one is still being issued.
// Reset: asynchronous, active low; clears all valid flags and the settings.
`default_nettype none

module flash_led_command_sequencer_unit import flcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // current_ma[11:0], flags_byte[19:12], current_reg_byte[27:20],
  // read_failed[28], zero fill above
  input  logic [31:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reg_address[7:0], reg_value[15:8], write_valid[16], status[17],
  // over_temp[18], overvolt_or_short[19], under_voltage[20], zero fill above
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  cfg_t       cfg_q;
  cmd_t       in_q;
  logic       in_valid_q;
  job_t       job_q, job_d;
  logic       job_valid_q;
  logic [1:0] idx_q;
  res_t       out_q;
  logic       out_valid_q;

  logic out_load, job_take, job_end, job_free, in_move, s_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MASK_ENABLE:  cfg_q.mask_enable            <= cfg_data_i[0];
        CFG_FLASH_LVL_EN: cfg_q.flash_level_configured <= cfg_data_i[0];
        CFG_TORCH_LVL_EN: cfg_q.torch_level_configured <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  flcs_encode u_encode (
    .cmd_i (in_q),
    .cfg_i (cfg_q),
    .job_o (job_d)
  );

  assign out_load      = !out_valid_q || m_axis_tready;
  assign job_take      = job_valid_q && out_load;
  assign job_end       = job_take && (idx_q == (job_q.cnt - 2'd1));
  assign job_free      = !job_valid_q || job_end;
  assign in_move       = in_valid_q && job_free;
  assign s_axis_tready = !in_valid_q || job_free;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_take) begin
        in_valid_q <= 1'b1;
      end else if (in_move) begin
        in_valid_q <= 1'b0;
      end
      if (in_move) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (job_end) begin
        job_valid_q <= 1'b0;
      end else if (job_take) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= job_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_q.opcode           <= s_axis_tuser;
      in_q.current_ma       <= s_axis_tdata[11:0];
      in_q.flags_byte       <= s_axis_tdata[19:12];
      in_q.current_reg_byte <= s_axis_tdata[27:20];
      in_q.read_failed      <= s_axis_tdata[28];
    end
    if (in_move) begin
      job_q <= job_d;
    end
    if (job_take) begin
      out_q <= job_q.res[idx_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {3'b000, out_q.under_voltage, out_q.overvolt_or_short,
                          out_q.over_temp, out_q.status, out_q.write_valid,
                          out_q.reg_value, out_q.reg_address};

endmodule

`default_nettype wire

// File: rtl/flcs_encode.sv
// ----------------------------------------------------------------------------
// flcs_encode
// Turns one command into its list of driver register writes, or one status-only result if aborted.
// ----------------------------------------------------------------------------
`default_nettype none

module flcs_encode import flcs_pkg::*; (
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  output job_t job_o
);

  logic [3:0] flash_lvl;
  logic [2:0] torch_lvl;
  logic [7:0] en_flash;
  logic       ot, ovs, uv;

  always_comb begin
    if (!cfg_i.flash_level_configured || (cmd_i.current_ma == '0)) begin
      flash_lvl = FLASH_DEF_LVL;
    end else if (cmd_i.current_ma >= FLASH_MAX_MA) begin
      flash_lvl = FLASH_HIGH_LVL;
    end else begin
      flash_lvl = flash_nearest(cmd_i.current_ma);
    end
  end

  always_comb begin
    if (!cfg_i.torch_level_configured || (cmd_i.current_ma == '0)) begin
      torch_lvl = TORCH_DEF_LVL;
    end else if (cmd_i.current_ma > TORCH_MAX_MA) begin
      torch_lvl = TORCH_HIGH_LVL;
    end else begin
      torch_lvl = torch_nearest(cmd_i.current_ma);
    end
  end

  assign en_flash = EN_FLASH_BASE | (cfg_i.mask_enable ? EN_TX_MASK : EN_VIN_MON)
                  | ((cmd_i.opcode == OP_STROBE) ? EN_STROBE : 8'h00);

  assign ot  = cmd_i.flags_byte[1];
  assign ovs = cmd_i.flags_byte[3] | cmd_i.flags_byte[2];
  assign uv  = cmd_i.flags_byte[4];

  always_comb begin
    job_o = '0;
    if (cmd_i.opcode == OP_OFF) begin
      job_o.cnt                = 2'd1;
      job_o.res[0].reg_address = ADDR_ENABLE;
      job_o.res[0].reg_value   = EN_OFF;
      job_o.res[0].write_valid = 1'b1;
      job_o.res[0].last        = 1'b1;
    end else if (cmd_i.read_failed) begin
      // aborted: single status-only result
      job_o.cnt           = 2'd1;
      job_o.res[0].status = 1'b1;
      job_o.res[0].last   = 1'b1;
    end else if (cmd_i.opcode == OP_TORCH) begin
      job_o.cnt                      = 2'd2;
      job_o.res[0].reg_address       = ADDR_CURRENT;
      job_o.res[0].reg_value         = {1'b0, torch_lvl, cmd_i.current_reg_byte[3:0]};
      job_o.res[0].write_valid       = 1'b1;
      job_o.res[0].over_temp         = ot;
      job_o.res[0].overvolt_or_short = ovs;
      job_o.res[0].under_voltage     = uv;
      job_o.res[1].reg_address       = ADDR_ENABLE;
      job_o.res[1].reg_value         = EN_TORCH;
      job_o.res[1].write_valid       = 1'b1;
      job_o.res[1].last              = 1'b1;
    end else begin
      job_o.cnt                      = 2'd3;
      job_o.res[0].reg_address       = ADDR_CURRENT;
      job_o.res[0].reg_value         = {cmd_i.current_reg_byte[7:4], flash_lvl};
      job_o.res[0].write_valid       = 1'b1;
      job_o.res[0].over_temp         = ot;
      job_o.res[0].overvolt_or_short = ovs;
      job_o.res[0].under_voltage     = uv;
      job_o.res[1].reg_address       = ADDR_FEATURES;
      job_o.res[1].reg_value         = FEATURES_VAL;
      job_o.res[1].write_valid       = 1'b1;
      job_o.res[2].reg_address       = ADDR_ENABLE;
      job_o.res[2].reg_value         = en_flash;
      job_o.res[2].write_valid       = 1'b1;
      job_o.res[2].last              = 1'b1;
    end
  end

endmodule

`default_nettype wire
